@@ src/jfs_pkg.sv @@
// Package for the JPEG frame size scanner: parse phases, status codes,
// marker constants and the structs passed between the scanner modules.
// No dependencies.
`default_nettype none

package jfs_pkg;

    localparam logic [7:0] FILL_BYTE = 8'hFF;
    localparam logic [7:0] SOI_BYTE  = 8'hD8;
    localparam logic [7:0] SOF_FIRST = 8'hC0;
    localparam logic [7:0] SOF_LAST  = 8'hC2;

    // Offsets inside the SOF segment body, counted from the first length byte.
    localparam logic [15:0] SOF_HEIGHT_HI = 16'd3;
    localparam logic [15:0] SOF_HEIGHT_LO = 16'd4;
    localparam logic [15:0] SOF_WIDTH_HI  = 16'd5;
    localparam logic [15:0] SOF_WIDTH_LO  = 16'd6;

    localparam logic [15:0] LEN_SELF = 16'd2;

    typedef enum logic [3:0] {
        PH_SOI0  = 4'd0,
        PH_SOI1  = 4'd1,
        PH_PAIR0 = 4'd2,
        PH_PAIR1 = 4'd3,
        PH_FILL  = 4'd4,
        PH_SOF   = 4'd5,
        PH_LEN0  = 4'd6,
        PH_LEN1  = 4'd7,
        PH_SKIP  = 4'd8,
        PH_DONE  = 4'd9
    } phase_t;

    typedef enum logic [1:0] {
        ST_FOUND  = 2'd0,
        ST_NO_SOI = 2'd1,
        ST_NO_SOF = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } item_t;

    typedef struct packed {
        logic [15:0] image_width;
        logic [15:0] image_height;
        status_t     status;
    } result_t;

    // A frame marker starts the SOF body; any other marker is read as a length.
    function automatic phase_t marker_phase(input logic [7:0] marker);
        phase_t ph;
        if (marker >= SOF_FIRST && marker <= SOF_LAST) begin
            ph = PH_SOF;
        end
        else begin
            ph = PH_LEN0;
        end
        return ph;
    endfunction

endpackage

`default_nettype wire

@@ src/jfs_if.sv @@
// Stream interfaces of the JPEG frame size scanner: the byte channel in
// and the size result channel out. No dependencies.
`default_nettype none

interface jfs_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_file;

    modport source (output valid, output data_byte, output end_of_file, input ready);
    modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface jfs_size_if;
    logic        valid;
    logic        ready;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [1:0]  status;

    modport source (output valid, output image_width, output image_height,
                    output status, input ready);
    modport sink   (input valid, input image_width, input image_height,
                    input status, output ready);
endinterface

`default_nettype wire

@@ src/jfs_in_stage.sv @@
// Input register of the JPEG frame size scanner: holds one byte request
// until the parser takes it. Depends on jfs_pkg.
`default_nettype none

module jfs_in_stage (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire jfs_pkg::item_t in_item,
    input  wire logic          take,
    output logic               item_valid,
    output jfs_pkg::item_t     item
);
    import jfs_pkg::*;

    logic  vld_reg;
    logic  vld_next;
    item_t item_reg;

    assign in_ready   = !vld_reg || take;
    assign item_valid = vld_reg;
    assign item       = item_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (in_valid && in_ready) begin
            vld_next = 1'b1;
        end
        else if (take) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= 1'b0;
        end
        else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

endmodule

`default_nettype wire

@@ src/jfs_parser.sv @@
// Marker parser of the JPEG frame size scanner: phase, counter and hold
// registers with the one-byte step logic. Depends on jfs_pkg.
`default_nettype none

module jfs_parser (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           step,
    input  wire jfs_pkg::item_t item,
    output logic                res_valid,
    output jfs_pkg::result_t    res
);
    import jfs_pkg::*;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [15:0] cnt_reg;
    logic [15:0] cnt_next;
    logic [7:0]  hold_reg;
    logic [7:0]  hold_next;
    logic [15:0] height_reg;
    logic [15:0] height_next;
    logic [15:0] word;
    logic [15:0] cnt_dec;

    assign word    = {hold_reg, item.data_byte};
    assign cnt_dec = cnt_reg - 16'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        hold_next   = hold_reg;
        height_next = height_reg;
        res_valid   = 1'b0;
        res         = '{image_width: 16'd0, image_height: 16'd0, status: ST_FOUND};

        if (step) begin
            unique case (phase_reg)
                PH_SOI0:
                begin
                    hold_next  = item.data_byte;
                    phase_next = PH_SOI1;
                end
                PH_SOI1:
                begin
                    if (hold_reg != FILL_BYTE || item.data_byte != SOI_BYTE) begin
                        res_valid  = 1'b1;
                        res.status = ST_NO_SOI;
                        phase_next = PH_DONE;
                    end
                    else begin
                        phase_next = PH_PAIR0;
                    end
                end
                PH_PAIR0:
                begin
                    hold_next  = item.data_byte;
                    phase_next = PH_PAIR1;
                end
                PH_PAIR1:
                begin
                    if (hold_reg != FILL_BYTE) begin
                        phase_next = PH_PAIR0;
                    end
                    else if (item.data_byte == FILL_BYTE) begin
                        phase_next = PH_FILL;
                    end
                    else begin
                        phase_next = marker_phase(item.data_byte);
                        cnt_next   = 16'd0;
                    end
                end
                PH_FILL:
                begin
                    if (item.data_byte != FILL_BYTE) begin
                        phase_next = marker_phase(item.data_byte);
                        cnt_next   = 16'd0;
                    end
                end
                PH_SOF:
                begin
                    if (cnt_reg == SOF_HEIGHT_HI || cnt_reg == SOF_WIDTH_HI) begin
                        hold_next = item.data_byte;
                    end
                    else if (cnt_reg == SOF_HEIGHT_LO) begin
                        height_next = word;
                    end
                    else if (cnt_reg == SOF_WIDTH_LO) begin
                        res_valid        = 1'b1;
                        res.image_width  = word;
                        res.image_height = height_reg;
                        res.status       = ST_FOUND;
                        phase_next       = PH_DONE;
                    end
                    cnt_next = cnt_reg + 16'd1;
                end
                PH_LEN0:
                begin
                    hold_next  = item.data_byte;
                    phase_next = PH_LEN1;
                end
                PH_LEN1:
                begin
                    // A length of two or less covers only itself.
                    if (word > LEN_SELF) begin
                        cnt_next   = word - LEN_SELF;
                        phase_next = PH_SKIP;
                    end
                    else begin
                        phase_next = PH_PAIR0;
                    end
                end
                PH_SKIP:
                begin
                    cnt_next = cnt_dec;
                    if (cnt_dec == 16'd0) begin
                        phase_next = PH_PAIR0;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase

            // The last byte closes the file: report if nothing was reported yet.
            if (item.end_of_file) begin
                if (!res_valid && phase_next != PH_DONE) begin
                    res_valid        = 1'b1;
                    res.image_width  = 16'd0;
                    res.image_height = 16'd0;
                    res.status       = (phase_next == PH_SOI1) ? ST_NO_SOI : ST_NO_SOF;
                end
                phase_next  = PH_SOI0;
                cnt_next    = 16'd0;
                hold_next   = 8'd0;
                height_next = 16'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg  <= PH_SOI0;
            cnt_reg    <= 16'd0;
            hold_reg   <= 8'd0;
            height_reg <= 16'd0;
        end
        else begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            hold_reg   <= hold_next;
            height_reg <= height_next;
        end
    end

endmodule

`default_nettype wire

@@ src/jpeg_frame_size_scan.sv @@
// Top level of the JPEG frame size scanner: input register, parser and
// result register. Depends on jfs_pkg, jfs_if, jfs_in_stage, jfs_parser.
//
//   channel   direction   payload                              per request
//   bytes     in          data_byte, end_of_file               one file byte
//   sizes     out         image_width, image_height, status    one per file
//
// A byte is taken every cycle while the result side keeps up; a result
// is presented once the byte that decides it has passed the input register
// and the parser step and is held in the result register. The throughput is
// set by the combinational parser step between the two registers.
// Reset clears the parse phase and all valid flags; the next byte is taken
// as the first byte of a file.
// A result that is not taken holds the parser; the input register then
// keeps one byte and bytes.ready drops.
`default_nettype none

module jpeg_frame_size_scan (
    input  wire logic   clk,
    input  wire logic   rst_n,
    jfs_byte_if.sink    bytes,
    jfs_size_if.source  sizes
);
    import jfs_pkg::*;

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    step;
    logic    res_valid;
    result_t res;
    logic    out_vld_reg;
    result_t out_reg;

    assign in_item.data_byte   = bytes.data_byte;
    assign in_item.end_of_file = bytes.end_of_file;

    // The parser steps only when the result register can take its output.
    assign step = item_valid && (!out_vld_reg || sizes.ready);

    jfs_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (bytes.valid),
        .in_ready   (bytes.ready),
        .in_item    (in_item),
        .take       (step),
        .item_valid (item_valid),
        .item       (item)
    );

    jfs_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_vld_reg <= 1'b0;
        end
        else if (step) begin
            out_vld_reg <= res_valid;
        end
        else if (sizes.ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && res_valid) begin
            out_reg <= res;
        end
    end

    assign sizes.valid        = out_vld_reg;
    assign sizes.image_width  = out_reg.image_width;
    assign sizes.image_height = out_reg.image_height;
    assign sizes.status       = out_reg.status;

endmodule

`default_nettype wire

@@ dv/jpeg_frame_size_scan_test.sv @@
// Testbench for jpeg_frame_size_scan: streams JPEG-like byte files through the block and
// checks every frame size result against a predictor of the byte parser.
// Depends on jfs_pkg, jfs_if and the jpeg_frame_size_scan RTL.
`timescale 1ns / 1ps

module jpeg_frame_size_scan_test;
    import jfs_pkg::*;

    typedef logic [7:0] octet_q_t[$];

    logic clk;
    logic rst_n;

    jfs_byte_if byte_ch();
    jfs_size_if size_ch();

    jpeg_frame_size_scan dut (
        .clk   (clk),
        .rst_n (rst_n),
        .bytes (byte_ch),
        .sizes (size_ch)
    );

    item_t   file_bytes[$];
    result_t pending_sizes[$];

    int sender_idle_pct;
    int receiver_idle_pct;
    int mismatch_count;
    bit byte_taken;

    // Predictor state.
    phase_t      scan_phase;
    logic [15:0] body_index;
    logic [7:0]  hold_byte;
    logic [15:0] frame_height;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic clear_scan();
        scan_phase   = PH_SOI0;
        body_index   = '0;
        hold_byte    = '0;
        frame_height = '0;
    endtask

    task automatic open_segment(input logic [7:0] marker);
        if (marker >= SOF_FIRST && marker <= SOF_LAST)
        begin
            scan_phase = PH_SOF;
            body_index = '0;
        end
        else
        begin
            scan_phase = PH_LEN0;
        end
    endtask

    // Advances the parser by one byte and queues the result that it decides, if any.
    task automatic scan_byte(input logic [7:0] b, input logic last);
        result_t     res;
        bit          have;
        logic [15:0] seg_len;
        have = 1'b0;
        res.image_width  = '0;
        res.image_height = '0;
        res.status       = ST_FOUND;
        case (scan_phase)
            PH_SOI0:
            begin
                hold_byte  = b;
                scan_phase = PH_SOI1;
            end
            PH_SOI1:
            begin
                if (hold_byte != FILL_BYTE || b != SOI_BYTE)
                begin
                    res.status = ST_NO_SOI;
                    have       = 1'b1;
                    scan_phase = PH_DONE;
                end
                else
                begin
                    scan_phase = PH_PAIR0;
                end
            end
            PH_PAIR0:
            begin
                hold_byte  = b;
                scan_phase = PH_PAIR1;
            end
            PH_PAIR1:
            begin
                if (hold_byte != FILL_BYTE)
                    scan_phase = PH_PAIR0;
                else if (b == FILL_BYTE)
                    scan_phase = PH_FILL;
                else
                    open_segment(b);
            end
            PH_FILL:
            begin
                if (b != FILL_BYTE)
                    open_segment(b);
            end
            PH_SOF:
            begin
                if (body_index == SOF_HEIGHT_HI || body_index == SOF_WIDTH_HI)
                begin
                    hold_byte = b;
                end
                else if (body_index == SOF_HEIGHT_LO)
                begin
                    frame_height = {hold_byte, b};
                end
                else if (body_index == SOF_WIDTH_LO)
                begin
                    res.image_width  = {hold_byte, b};
                    res.image_height = frame_height;
                    have             = 1'b1;
                    scan_phase       = PH_DONE;
                end
                body_index = body_index + 16'd1;
            end
            PH_LEN0:
            begin
                hold_byte  = b;
                scan_phase = PH_LEN1;
            end
            PH_LEN1:
            begin
                seg_len = {hold_byte, b};
                if (seg_len > LEN_SELF)
                begin
                    body_index = seg_len - LEN_SELF;
                    scan_phase = PH_SKIP;
                end
                else
                begin
                    scan_phase = PH_PAIR0;
                end
            end
            PH_SKIP:
            begin
                body_index = body_index - 16'd1;
                if (body_index == '0)
                    scan_phase = PH_PAIR0;
            end
            default:
            begin
            end
        endcase
        if (last)
        begin
            if (!have && scan_phase != PH_DONE)
            begin
                res.status = (scan_phase == PH_SOI1) ? ST_NO_SOI : ST_NO_SOF;
                have       = 1'b1;
            end
            clear_scan();
        end
        if (have)
            pending_sizes = {pending_sizes, res};
    endtask

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s", $realtime, what);
    endtask

    // Driver: a request stays up until it is taken; new ones come from file_bytes.
    always @(negedge clk)
    begin : drive_bytes
        item_t next_req;
        bit    busy;
        busy = byte_ch.valid && !byte_taken;
        if (!rst_n)
        begin
            byte_ch.valid <= 1'b0;
        end
        else if (!busy)
        begin
            if (file_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                next_req = file_bytes.pop_front();
                byte_ch.valid       <= 1'b1;
                byte_ch.data_byte   <= next_req.data_byte;
                byte_ch.end_of_file <= next_req.end_of_file;
            end
            else
            begin
                byte_ch.valid <= 1'b0;
            end
        end
        size_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // Monitor: predicts on every byte taken and checks every size result taken.
    always @(posedge clk)
    begin : watch_ports
        result_t want;
        if (rst_n)
        begin
            if (byte_ch.valid && byte_ch.ready)
                scan_byte(byte_ch.data_byte, byte_ch.end_of_file);
            byte_taken <= byte_ch.valid && byte_ch.ready;
            if (size_ch.valid && size_ch.ready)
            begin
                if (pending_sizes.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected result w=%h h=%h st=%0d",
                        size_ch.image_width, size_ch.image_height, size_ch.status));
                end
                else
                begin
                    want = pending_sizes.pop_front();
                    if (size_ch.image_width !== want.image_width
                        || size_ch.image_height !== want.image_height
                        || size_ch.status !== want.status)
                    begin
                        flag_mismatch($sformatf(
                            "expected w=%h h=%h st=%0d, got w=%h h=%h st=%0d",
                            want.image_width, want.image_height, want.status,
                            size_ch.image_width, size_ch.image_height, size_ch.status));
                    end
                end
            end
        end
    end

    // Appends one byte to the end of a file under construction.
    task automatic add_octet(ref octet_q_t f, input logic [7:0] b);
        f = {f, b};
    endtask

    task automatic queue_file(input octet_q_t f);
        item_t it;
        for (int i = 0; i < f.size(); i++)
        begin
            it.data_byte   = f[i];
            it.end_of_file = (i == f.size() - 1);
            file_bytes = {file_bytes, it};
        end
    endtask

    // A marker opens with 0xFF and sometimes a few fill bytes.
    task automatic marker_lead(ref octet_q_t f);
        add_octet(f, FILL_BYTE);
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 2)) add_octet(f, FILL_BYTE);
    endtask

    function automatic logic [15:0] pick_dim();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_jpeg(ref octet_q_t f);
        int          cut;
        int          len;
        logic [7:0]  marker;
        logic [15:0] dim;
        f.delete();
        add_octet(f, FILL_BYTE);
        add_octet(f, SOI_BYTE);
        repeat ($urandom_range(3))
        begin
            if ($urandom_range(3) == 0)
            begin
                // A pair that does not open with 0xFF is dropped whole.
                add_octet(f, 8'($urandom_range(8'hFE)));
                add_octet(f, 8'($urandom));
            end
            else
            begin
                marker_lead(f);
                do
                    marker = 8'($urandom);
                while (marker == FILL_BYTE || (marker >= SOF_FIRST && marker <= SOF_LAST));
                add_octet(f, marker);
                case ($urandom_range(99))
                    0, 1, 2, 3, 4, 5, 6, 7: len = $urandom_range(2);
                    8: len = 16'h0100 + $urandom_range(8);
                    9, 10:
                    begin
                        // A long segment that the file ends inside.
                        len = $urandom_range(16'h0200, 16'hFFFF);
                        add_octet(f, len[15:8]);
                        add_octet(f, len[7:0]);
                        repeat ($urandom_range(4)) add_octet(f, 8'($urandom));
                        return;
                    end
                    default: len = $urandom_range(3, 10);
                endcase
                add_octet(f, len[15:8]);
                add_octet(f, len[7:0]);
                if (len > 2)
                    repeat (len - 2) add_octet(f, 8'($urandom));
            end
        end
        marker_lead(f);
        add_octet(f, 8'(SOF_FIRST + $urandom_range(2)));
        repeat (3) add_octet(f, 8'($urandom));
        dim = pick_dim();
        add_octet(f, dim[15:8]);
        add_octet(f, dim[7:0]);
        dim = pick_dim();
        add_octet(f, dim[15:8]);
        add_octet(f, dim[7:0]);
        repeat ($urandom_range(3)) add_octet(f, 8'($urandom));
        if ($urandom_range(6) == 0)
        begin
            cut = $urandom_range(1, f.size() - 1);
            f = f[0:cut-1];
        end
    endtask

    task automatic noise_file(ref octet_q_t f);
        int n;
        n = $urandom_range(1, 10);
        f.delete();
        repeat (n) add_octet(f, 8'($urandom));
        if (n >= 2)
        begin
            case ($urandom_range(3))
                0, 1:
                begin
                    f[0] = FILL_BYTE;
                    f[1] = SOI_BYTE;
                end
                2: f[0] = FILL_BYTE;
                default:
                begin
                end
            endcase
        end
    endtask

    // Holds the sender until every queued byte is taken and every result has come.
    task automatic drain();
        while (file_bytes.size() != 0 || byte_ch.valid || pending_sizes.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        octet_q_t f;
        int       queued;
        clk                 = 1'b0;
        rst_n               = 1'b0;
        byte_ch.valid       = 1'b0;
        byte_ch.data_byte   = '0;
        byte_ch.end_of_file = 1'b0;
        size_ch.ready       = 1'b0;
        byte_taken          = 1'b0;
        mismatch_count      = 0;
        sender_idle_pct     = 37;
        receiver_idle_pct   = 45;
        clear_scan();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // First byte is also the final one: bad start of image.
        f = '{8'h00};
        queue_file(f);
        // Bad start of image decided on the second byte; the rest is ignored.
        f = '{8'hFF, 8'hD7, 8'h11};
        queue_file(f);
        // File ends right after a good start of image.
        f = '{8'hFF, 8'hD8};
        queue_file(f);
        // Dropped pair, fill bytes, a marker with no length of its own read with
        // length 1, a one-byte skip, then a frame of height FFFF and width 0.
        f = '{8'hFF, 8'hD8, 8'h12, 8'h34, 8'hFF, 8'hFF, 8'hFF, 8'hD0, 8'h00, 8'h01,
              8'hFF, 8'hE1, 8'h00, 8'h03, 8'hAB,
              8'hFF, 8'hC2, 8'h00, 8'h11, 8'h08, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h55};
        queue_file(f);
        // Frame marker whose last width byte is the final byte of the file.
        f = '{8'hFF, 8'hD8, 8'hFF, 8'hC1, 8'h00, 8'h11, 8'h08, 8'h00, 8'h00,
              8'hFF, 8'hFF};
        queue_file(f);
        // 0xC3 is not a frame marker; lengths 0 and 2; a skip that runs past the end.
        f = '{8'hFF, 8'hD8, 8'hFF, 8'hC3, 8'h00, 8'h00, 8'hFF, 8'hDB, 8'h00, 8'h02,
              8'hFF, 8'hE0, 8'h00, 8'h09, 8'h11};
        queue_file(f);
        // Frame body cut off by the end of the file.
        f = '{8'hFF, 8'hD8, 8'hFF, 8'hC0, 8'h00, 8'h11, 8'h08, 8'h7F};
        queue_file(f);
        drain();

        for (int ph = 0; ph < 3; ph++)
        begin
            sender_idle_pct   = (ph == 0) ? 37 : (ph == 1) ? 45 : 0;
            receiver_idle_pct = (ph == 0) ? 45 : (ph == 1) ? 37 : 0;
            queued = 0;
            while (queued < 235)
            begin
                if ($urandom_range(4) == 0)
                    noise_file(f);
                else
                    random_jpeg(f);
                queue_file(f);
                queued += f.size();
            end
            drain();
        end

        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
